### hdl/fresnel_dielectric_reflectance_assert.svh
// Assertion macros used by the Fresnel reflectance RTL.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_ASSERT_SVH

// Implication checked in the same cycle, suspended during reset.
`define FDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle, suspended during reset.
`define FDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/fdr_pkg.sv
// Types, constants and arithmetic step functions of the Fresnel reflectance pipeline.
`timescale 1ns / 1ps

package fdr_pkg;

    // Input vector format and normalisation.
    localparam int VECTOR_WIDTH = 16;
    localparam int MAG_W        = VECTOR_WIDTH;
    localparam int POS_W        = $clog2(MAG_W);
    localparam int SCALE_MSB    = 14;
    localparam int SCALED_W     = SCALE_MSB + 1;
    localparam int COMP_W       = SCALED_W + 1;
    localparam int SHIFT_W      = MAG_W + SCALE_MSB;
    localparam int PROD_W       = 2 * COMP_W;
    localparam int SQ_W         = 2 * SCALED_W;
    localparam int DOT_W        = PROD_W + 2;
    localparam int LEN_W        = 32;

    // Index, angle and amplitude widths.
    localparam int ETA_W       = 16;
    localparam int Q30_W       = 31;
    localparam int QSQ_W       = 2 * Q30_W;
    localparam int MUL_W       = ETA_W + Q30_W;
    localparam int AMP_W       = MUL_W + 1;
    localparam int RATIO_DEN_W = 33;
    localparam int RSH_W       = $clog2(AMP_W - RATIO_DEN_W + 1);
    localparam int OUT_W       = 16;
    localparam int SUM_W       = QSQ_W + 1;

    // Iterative units.
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int OP_W       = 2 * ROOT_W;
    localparam int SREM_W     = ROOT_W + 4;
    localparam int DIV_STEPS  = 32;
    localparam int DVS_W      = 34;
    localparam int DREM_W     = DVS_W + 1;

    localparam logic [Q30_W-1:0] ONE_Q30   = Q30_W'(1) << 30;
    localparam logic [OP_W-1:0]  ONE_Q60   = OP_W'(1) << 60;
    localparam logic [OUT_W-1:0] ONE_Q15   = OUT_W'(1) << 15;
    localparam logic [SUM_W-1:0] ROUND_Q46 = SUM_W'(1) << 45;
    localparam int               SUM_SHIFT = 46;

    // Configuration registers.
    typedef enum logic [0:0] {
        REG_INDEX_OUTSIDE = 1'b0,
        REG_INDEX_INSIDE  = 1'b1
    } t_reg_index;

    localparam logic [ETA_W-1:0] RESET_INDEX_OUTSIDE = 16'd4096;
    localparam logic [ETA_W-1:0] RESET_INDEX_INSIDE  = 16'd6144;

    // Values that travel alongside each request through the whole pipeline.
    typedef struct packed {
        logic               vld;
        logic               degen;
        logic               tir;
        logic [ETA_W-1:0]   eta_in;
        logic [ETA_W-1:0]   eta_tr;
        logic [LEN_W-1:0]   a;
        logic [Q30_W-1:0]   cosi;
        logic [Q30_W-1:0]   sini;
    } t_side;

    // One stage of the digit-by-digit square root.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    // One stage of the restoring divider.
    typedef struct packed {
        logic [DIV_STEPS-1:0] lo;
        logic [DREM_W-1:0]    rem;
        logic [DVS_W-1:0]     dvs;
        logic [DIV_STEPS-1:0] quo;
    } t_div;

    // Bring in two radicand bits and decide one root bit.
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        logic [SREM_W+1:0] rs;
        logic [SREM_W+1:0] trial;
        t_sqrt             o;
        rs    = {s.rem, s.op[OP_W-1 -: 2]};
        trial = {4'b0000, s.root, 2'b01};
        o.op  = {s.op[OP_W-3:0], 2'b00};
        if (rs >= trial) begin
            o.rem  = SREM_W'(rs - trial);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = rs[SREM_W-1:0];
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // Start a square root of a full-width radicand.
    function automatic t_sqrt sqrt_init(input logic [OP_W-1:0] v);
        t_sqrt o;
        o.op   = v;
        o.rem  = '0;
        o.root = '0;
        return o;
    endfunction

    // Bring in one dividend bit and decide one quotient bit.
    function automatic t_div div_step(input t_div s);
        logic [DREM_W:0] rs;
        t_div            o;
        rs    = {s.rem, s.lo[DIV_STEPS-1]};
        o.lo  = {s.lo[DIV_STEPS-2:0], 1'b0};
        o.dvs = s.dvs;
        if (rs >= {2'b00, s.dvs}) begin
            o.rem = DREM_W'(rs - {2'b00, s.dvs});
            o.quo = {s.quo[DIV_STEPS-2:0], 1'b1};
        end else begin
            o.rem = rs[DREM_W-1:0];
            o.quo = {s.quo[DIV_STEPS-2:0], 1'b0};
        end
        return o;
    endfunction

    // Start a division; the upper half of the dividend must be below the divisor.
    function automatic t_div div_init(input logic [OP_W-1:0] dvd, input logic [DVS_W-1:0] dvs);
        t_div o;
        o.lo  = dvd[DIV_STEPS-1:0];
        o.rem = DREM_W'(dvd[OP_W-1:DIV_STEPS]);
        o.dvs = dvs;
        o.quo = '0;
        return o;
    endfunction

    // Quotient clamped to one in Q30.
    function automatic logic [Q30_W-1:0] clamp_q30(input logic [DIV_STEPS-1:0] q);
        logic [Q30_W-1:0] r;
        if (q > DIV_STEPS'(ONE_Q30)) begin
            r = ONE_Q30;
        end else begin
            r = q[Q30_W-1:0];
        end
        return r;
    endfunction

    // Position of the highest set bit of a magnitude.
    function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    // Right shift that brings an amplitude denominator below 2^33.
    function automatic logic [RSH_W-1:0] ratio_shift(input logic [AMP_W-1:0] den);
        logic [RSH_W-1:0] s;
        s = '0;
        for (int i = RATIO_DEN_W; i < AMP_W; i++) begin
            if (den[i]) begin
                s = RSH_W'(i - RATIO_DEN_W + 1);
            end
        end
        return s;
    endfunction

endpackage

### hdl/fresnel_dielectric_reflectance.sv
// Pipelined unpolarised Fresnel reflectance of a dielectric boundary.
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ---------------------------------------
//  input     in         i_valid / o_stall          i_dir_x/y/z, i_normal_x/y/z
//  output    out        o_valid / i_stall          o_reflectance, o_total_reflection,
//                                                  o_degenerate
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request enters per cycle while the pipeline is not stalled.
// The pipeline holds three 32-stage square-root units and four 32-stage dividers
// (two of them side by side), plus the scaling, product and output stages.
// Reset (synchronous, active low) clears every valid bit and loads the index registers.
// The whole pipeline holds while a result waits under i_stall; o_stall then rises.
`timescale 1ns / 1ps
`include "fresnel_dielectric_reflectance_assert.svh"

module fresnel_dielectric_reflectance
    import fdr_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [VECTOR_WIDTH-1:0] i_dir_x,
    input  logic signed [VECTOR_WIDTH-1:0] i_dir_y,
    input  logic signed [VECTOR_WIDTH-1:0] i_dir_z,
    input  logic signed [VECTOR_WIDTH-1:0] i_normal_x,
    input  logic signed [VECTOR_WIDTH-1:0] i_normal_y,
    input  logic signed [VECTOR_WIDTH-1:0] i_normal_z,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [OUT_W-1:0]               o_reflectance,
    output logic                           o_total_reflection,
    output logic                           o_degenerate,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [0:0]                     i_cfg_index,
    input  logic [ETA_W-1:0]               i_cfg_data
);

    logic                           w_adv;
    logic signed [VECTOR_WIDTH-1:0] w_raw [6];

    logic [ETA_W-1:0] r_index_outside;
    logic [ETA_W-1:0] r_index_inside;

    // Scaling stages.
    t_side                     n_p1_sd, r_p1_sd;
    logic [MAG_W-1:0]          n_p1_mag [6];
    logic [MAG_W-1:0]          r_p1_mag [6];
    logic                      n_p1_neg [6];
    logic                      r_p1_neg [6];
    logic [MAG_W-1:0]          n_p1_dtop, r_p1_dtop, n_p1_ntop, r_p1_ntop;
    t_side                     n_p2_sd, r_p2_sd;
    logic signed [COMP_W-1:0]  n_p2_v [6];
    logic signed [COMP_W-1:0]  r_p2_v [6];

    // Products and lengths.
    logic signed [PROD_W-1:0]  n_p3_dot [3];
    logic signed [PROD_W-1:0]  r_p3_dot [3];
    logic [SQ_W-1:0]           n_p3_dsq [3];
    logic [SQ_W-1:0]           r_p3_dsq [3];
    logic [SQ_W-1:0]           n_p3_nsq [3];
    logic [SQ_W-1:0]           r_p3_nsq [3];
    t_side                     r_p3_sd;
    t_side                     n_p4_sd, r_p4_sd;
    logic [LEN_W-1:0]          n_p4_dd, r_p4_dd, n_p4_nn, r_p4_nn;
    t_side                     r_p5_sd;
    logic [OP_W-1:0]           r_p5_prod;

    // Iterative units with their side values.
    t_sqrt r_sa [0:SQRT_STEPS];
    t_side r_sa_sd [0:SQRT_STEPS];
    t_div  r_dc [0:DIV_STEPS];
    t_side r_dc_sd [0:DIV_STEPS];
    t_side n_q1_sd, r_q1_sd;
    t_side r_q2_sd;
    logic [QSQ_W-1:0] r_q2_csq;
    t_sqrt r_sb [0:SQRT_STEPS];
    t_side r_sb_sd [0:SQRT_STEPS];
    t_side n_q3_sd, r_q3_sd;
    logic [MUL_W-1:0] r_q3_min;
    t_side n_ds0_sd;
    t_div  r_ds [0:DIV_STEPS];
    t_side r_ds_sd [0:DIV_STEPS];
    t_side r_q5_sd;
    logic [Q30_W-1:0] r_q5_sint;
    t_side r_q6_sd;
    logic [QSQ_W-1:0] r_q6_ssq;
    t_sqrt r_sc [0:SQRT_STEPS];
    t_side r_sc_sd [0:SQRT_STEPS];

    // Amplitude stages.
    t_side                r_q7_sd;
    logic [MUL_W-1:0]     r_q7_tc, r_q7_ic, r_q7_icos, r_q7_tcos;
    logic [Q30_W-1:0]     w_cost;
    t_side                n_q8_sd, r_q8_sd;
    logic [AMP_W-1:0]     n_q8_npar, r_q8_npar, n_q8_dpar, r_q8_dpar;
    logic [AMP_W-1:0]     n_q8_nperp, r_q8_nperp, n_q8_dperp, r_q8_dperp;
    t_side                r_q9_sd;
    logic [RSH_W-1:0]     w_sh_par, w_sh_perp;
    logic [RATIO_DEN_W-1:0] r_q9_npar, r_q9_dpar, r_q9_nperp, r_q9_dperp;
    logic [RATIO_DEN_W-1:0] w_ncl_par, w_ncl_perp;
    t_div  r_dp [0:DIV_STEPS];
    t_div  r_dr [0:DIV_STEPS];
    t_side r_dp_sd [0:DIV_STEPS];
    t_side r_q11_sd;
    logic [QSQ_W-1:0] r_q11_rp2, r_q11_rs2;

    // Output register.
    logic [SUM_W-1:0]     w_sum;
    logic [SUM_W-1:0]     w_refl_full;
    logic [OUT_W-1:0]     n_out_refl;
    logic                 n_out_degen;
    logic                 r_out_vld;
    logic [OUT_W-1:0]     r_out_refl;
    logic                 r_out_tir;
    logic                 r_out_degen;

    // The pipeline moves unless a finished result is held back.
    assign w_adv       = !(r_out_vld && i_stall);
    assign o_stall     = !w_adv;
    assign o_cfg_ready = 1'b1;

    assign w_raw[0] = i_dir_x;
    assign w_raw[1] = i_dir_y;
    assign w_raw[2] = i_dir_z;
    assign w_raw[3] = i_normal_x;
    assign w_raw[4] = i_normal_y;
    assign w_raw[5] = i_normal_z;

    // Refractive index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_outside <= RESET_INDEX_OUTSIDE;
            r_index_inside  <= RESET_INDEX_INSIDE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INDEX_OUTSIDE: r_index_outside <= i_cfg_data;
                REG_INDEX_INSIDE:  r_index_inside  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: component magnitudes and the largest one of each vector.
    always_comb begin
        n_p1_sd     = '0;
        n_p1_sd.vld = i_valid;
        for (int i = 0; i < 6; i++) begin
            n_p1_neg[i] = w_raw[i][VECTOR_WIDTH-1];
            n_p1_mag[i] = n_p1_neg[i] ? MAG_W'(-w_raw[i]) : MAG_W'(w_raw[i]);
        end
        n_p1_dtop = n_p1_mag[0];
        n_p1_ntop = n_p1_mag[3];
        for (int i = 1; i < 3; i++) begin
            if (n_p1_mag[i] > n_p1_dtop) begin
                n_p1_dtop = n_p1_mag[i];
            end
            if (n_p1_mag[i+3] > n_p1_ntop) begin
                n_p1_ntop = n_p1_mag[i+3];
            end
        end
    end

    // Stage 2: scale each vector so that its largest magnitude lands in [2^14, 2^15).
    always_comb begin
        logic [POS_W-1:0]    pos;
        logic [SHIFT_W-1:0]  shv;
        logic [SCALED_W-1:0] sc;
        n_p2_sd       = r_p1_sd;
        n_p2_sd.degen = (r_p1_dtop == '0) || (r_p1_ntop == '0);
        for (int i = 0; i < 6; i++) begin
            pos       = (i < 3) ? msb_pos(r_p1_dtop) : msb_pos(r_p1_ntop);
            shv       = {r_p1_mag[i], {SCALE_MSB{1'b0}}} >> pos;
            sc        = shv[SCALED_W-1:0];
            n_p2_v[i] = r_p1_neg[i] ? -$signed({1'b0, sc}) : $signed({1'b0, sc});
        end
    end

    // Stage 3: component products.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p3_dot[i] = PROD_W'(r_p2_v[i]) * PROD_W'(r_p2_v[i+3]);
            n_p3_dsq[i] = SQ_W'(PROD_W'(r_p2_v[i]) * PROD_W'(r_p2_v[i]));
            n_p3_nsq[i] = SQ_W'(PROD_W'(r_p2_v[i+3]) * PROD_W'(r_p2_v[i+3]));
        end
    end

    // Stage 4: dot product, squared lengths, side of the surface and index order.
    always_comb begin
        logic signed [DOT_W-1:0] dot;
        dot     = DOT_W'(r_p3_dot[0]) + DOT_W'(r_p3_dot[1]) + DOT_W'(r_p3_dot[2]);
        n_p4_sd = r_p3_sd;
        n_p4_dd = LEN_W'(r_p3_dsq[0]) + LEN_W'(r_p3_dsq[1]) + LEN_W'(r_p3_dsq[2]);
        n_p4_nn = LEN_W'(r_p3_nsq[0]) + LEN_W'(r_p3_nsq[1]) + LEN_W'(r_p3_nsq[2]);
        if (dot[DOT_W-1]) begin
            n_p4_sd.a      = LEN_W'(-dot);
            n_p4_sd.eta_in = r_index_outside;
            n_p4_sd.eta_tr = r_index_inside;
        end else begin
            n_p4_sd.a      = LEN_W'(dot);
            n_p4_sd.eta_in = r_index_inside;
            n_p4_sd.eta_tr = r_index_outside;
        end
        if (n_p4_sd.eta_tr == '0) begin
            n_p4_sd.degen = 1'b1;
        end
    end

    // Stages 1 to 5 registers; the fifth multiplies the squared lengths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_sd.vld <= 1'b0;
            r_p2_sd.vld <= 1'b0;
            r_p3_sd.vld <= 1'b0;
            r_p4_sd.vld <= 1'b0;
            r_p5_sd.vld <= 1'b0;
        end else if (w_adv) begin
            r_p1_sd   <= n_p1_sd;
            r_p1_mag  <= n_p1_mag;
            r_p1_neg  <= n_p1_neg;
            r_p1_dtop <= n_p1_dtop;
            r_p1_ntop <= n_p1_ntop;
            r_p2_sd   <= n_p2_sd;
            r_p2_v    <= n_p2_v;
            r_p3_sd   <= r_p2_sd;
            r_p3_dot  <= n_p3_dot;
            r_p3_dsq  <= n_p3_dsq;
            r_p3_nsq  <= n_p3_nsq;
            r_p4_sd   <= n_p4_sd;
            r_p4_dd   <= n_p4_dd;
            r_p4_nn   <= n_p4_nn;
            r_p5_sd   <= r_p4_sd;
            r_p5_prod <= {{(OP_W-LEN_W){1'b0}}, r_p4_dd} * {{(OP_W-LEN_W){1'b0}}, r_p4_nn};
        end
    end

    // Square root of dd*nn: the denominator of the cosine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa_sd[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_sa_sd[0] <= r_p5_sd;
            r_sa[0]    <= sqrt_init(r_p5_prod);
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sa
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sa_sd[k].vld <= 1'b0;
            end else if (w_adv) begin
                r_sa_sd[k] <= r_sa_sd[k-1];
                r_sa[k]    <= sqrt_step(r_sa[k-1]);
            end
        end
    end

    // Cosine of incidence: |dot| * 2^30 / den.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_sd[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_dc_sd[0] <= r_sa_sd[SQRT_STEPS];
            r_dc[0]    <= div_init({2'b00, r_sa_sd[SQRT_STEPS].a, 30'd0},
                                   DVS_W'(r_sa[SQRT_STEPS].root));
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_dc
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dc_sd[k].vld <= 1'b0;
            end else if (w_adv) begin
                r_dc_sd[k] <= r_dc_sd[k-1];
                r_dc[k]    <= div_step(r_dc[k-1]);
            end
        end
    end

    always_comb begin
        n_q1_sd      = r_dc_sd[DIV_STEPS];
        n_q1_sd.cosi = clamp_q30(r_dc[DIV_STEPS].quo);
    end

    // Clamp the cosine, square it and start the sine root.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_sd.vld    <= 1'b0;
            r_q2_sd.vld    <= 1'b0;
            r_sb_sd[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_q1_sd    <= n_q1_sd;
            r_q2_sd    <= r_q1_sd;
            r_q2_csq   <= {{Q30_W{1'b0}}, r_q1_sd.cosi} * {{Q30_W{1'b0}}, r_q1_sd.cosi};
            r_sb_sd[0] <= r_q2_sd;
            r_sb[0]    <= sqrt_init(ONE_Q60 - OP_W'(r_q2_csq));
        end
    end

    // Sine of incidence.
    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sb_sd[k].vld <= 1'b0;
            end else if (w_adv) begin
                r_sb_sd[k] <= r_sb_sd[k-1];
                r_sb[k]    <= sqrt_step(r_sb[k-1]);
            end
        end
    end

    always_comb begin
        n_q3_sd      = r_sb_sd[SQRT_STEPS];
        n_q3_sd.sini = r_sb[SQRT_STEPS].root[Q30_W-1:0];
    end

    // Total reflection holds when eta_in * sin_i exceeds eta_tr in Q30.
    always_comb begin
        n_ds0_sd     = r_q3_sd;
        n_ds0_sd.tir = !r_q3_sd.degen && (r_q3_min > {1'b0, r_q3_sd.eta_tr, 30'd0});
    end

    // Snell's law: eta_in * sin_i, then the division by eta_tr.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q3_sd.vld    <= 1'b0;
            r_ds_sd[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_q3_sd    <= n_q3_sd;
            r_q3_min   <= MUL_W'(n_q3_sd.eta_in) * MUL_W'(n_q3_sd.sini);
            r_ds_sd[0] <= n_ds0_sd;
            r_ds[0]    <= div_init(OP_W'(r_q3_min), DVS_W'(r_q3_sd.eta_tr));
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_ds
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ds_sd[k].vld <= 1'b0;
            end else if (w_adv) begin
                r_ds_sd[k] <= r_ds_sd[k-1];
                r_ds[k]    <= div_step(r_ds[k-1]);
            end
        end
    end

    // Transmitted sine, its square and the start of the cosine root.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q5_sd.vld    <= 1'b0;
            r_q6_sd.vld    <= 1'b0;
            r_sc_sd[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_q5_sd    <= r_ds_sd[DIV_STEPS];
            r_q5_sint  <= clamp_q30(r_ds[DIV_STEPS].quo);
            r_q6_sd    <= r_q5_sd;
            r_q6_ssq   <= {{Q30_W{1'b0}}, r_q5_sint} * {{Q30_W{1'b0}}, r_q5_sint};
            r_sc_sd[0] <= r_q6_sd;
            r_sc[0]    <= sqrt_init(ONE_Q60 - OP_W'(r_q6_ssq));
        end
    end

    // Cosine of transmission.
    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sc
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sc_sd[k].vld <= 1'b0;
            end else if (w_adv) begin
                r_sc_sd[k] <= r_sc_sd[k-1];
                r_sc[k]    <= sqrt_step(r_sc[k-1]);
            end
        end
    end

    assign w_cost = r_sc[SQRT_STEPS].root[Q30_W-1:0];

    // Amplitude numerators and denominators; a vanishing denominator without total reflection is degenerate.
    always_comb begin
        n_q8_sd    = r_q7_sd;
        n_q8_dpar  = AMP_W'(r_q7_tc) + AMP_W'(r_q7_ic);
        n_q8_dperp = AMP_W'(r_q7_icos) + AMP_W'(r_q7_tcos);
        n_q8_npar  = (r_q7_tc >= r_q7_ic) ? AMP_W'(r_q7_tc - r_q7_ic)
                                          : AMP_W'(r_q7_ic - r_q7_tc);
        n_q8_nperp = (r_q7_icos >= r_q7_tcos) ? AMP_W'(r_q7_icos - r_q7_tcos)
                                              : AMP_W'(r_q7_tcos - r_q7_icos);
        if (!r_q7_sd.tir && ((n_q8_dpar == '0) || (n_q8_dperp == '0))) begin
            n_q8_sd.degen = 1'b1;
        end
    end

    assign w_sh_par  = ratio_shift(r_q8_dpar);
    assign w_sh_perp = ratio_shift(r_q8_dperp);

    // Each ratio's numerator is held no larger than its denominator.
    assign w_ncl_par  = (r_q9_npar > r_q9_dpar) ? r_q9_dpar : r_q9_npar;
    assign w_ncl_perp = (r_q9_nperp > r_q9_dperp) ? r_q9_dperp : r_q9_nperp;

    // Products, amplitude terms, the common down-shift and the start of both ratios.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q7_sd.vld    <= 1'b0;
            r_q8_sd.vld    <= 1'b0;
            r_q9_sd.vld    <= 1'b0;
            r_dp_sd[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_q7_sd    <= r_sc_sd[SQRT_STEPS];
            r_q7_tc    <= MUL_W'(r_sc_sd[SQRT_STEPS].eta_tr) * MUL_W'(r_sc_sd[SQRT_STEPS].cosi);
            r_q7_ic    <= MUL_W'(r_sc_sd[SQRT_STEPS].eta_in) * MUL_W'(w_cost);
            r_q7_icos  <= MUL_W'(r_sc_sd[SQRT_STEPS].eta_in) * MUL_W'(r_sc_sd[SQRT_STEPS].cosi);
            r_q7_tcos  <= MUL_W'(r_sc_sd[SQRT_STEPS].eta_tr) * MUL_W'(w_cost);
            r_q8_sd    <= n_q8_sd;
            r_q8_npar  <= n_q8_npar;
            r_q8_dpar  <= n_q8_dpar;
            r_q8_nperp <= n_q8_nperp;
            r_q8_dperp <= n_q8_dperp;
            r_q9_sd    <= r_q8_sd;
            r_q9_npar  <= RATIO_DEN_W'(r_q8_npar >> w_sh_par);
            r_q9_dpar  <= RATIO_DEN_W'(r_q8_dpar >> w_sh_par);
            r_q9_nperp <= RATIO_DEN_W'(r_q8_nperp >> w_sh_perp);
            r_q9_dperp <= RATIO_DEN_W'(r_q8_dperp >> w_sh_perp);
            r_dp_sd[0] <= r_q9_sd;
            r_dp[0]    <= div_init({1'b0, w_ncl_par, 30'd0}, DVS_W'(r_q9_dpar));
            r_dr[0]    <= div_init({1'b0, w_ncl_perp, 30'd0}, DVS_W'(r_q9_dperp));
        end
    end

    // Parallel and perpendicular amplitude ratios side by side.
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_dp
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dp_sd[k].vld <= 1'b0;
            end else if (w_adv) begin
                r_dp_sd[k] <= r_dp_sd[k-1];
                r_dp[k]    <= div_step(r_dp[k-1]);
                r_dr[k]    <= div_step(r_dr[k-1]);
            end
        end
    end

    // Mean of the squared amplitudes, rounded, with the special cases on top.
    always_comb begin
        w_sum       = SUM_W'(r_q11_rp2) + SUM_W'(r_q11_rs2) + ROUND_Q46;
        w_refl_full = w_sum >> SUM_SHIFT;
        n_out_degen = r_q11_sd.degen;
        if (r_q11_sd.degen || r_q11_sd.tir || (w_refl_full > SUM_W'(ONE_Q15))) begin
            n_out_refl = ONE_Q15;
        end else begin
            n_out_refl = w_refl_full[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q11_sd.vld <= 1'b0;
            r_out_vld    <= 1'b0;
        end else if (w_adv) begin
            r_q11_sd    <= r_dp_sd[DIV_STEPS];
            r_q11_rp2   <= {{Q30_W{1'b0}}, r_dp[DIV_STEPS].quo[Q30_W-1:0]}
                         * {{Q30_W{1'b0}}, r_dp[DIV_STEPS].quo[Q30_W-1:0]};
            r_q11_rs2   <= {{Q30_W{1'b0}}, r_dr[DIV_STEPS].quo[Q30_W-1:0]}
                         * {{Q30_W{1'b0}}, r_dr[DIV_STEPS].quo[Q30_W-1:0]};
            r_out_vld   <= r_q11_sd.vld;
            r_out_refl  <= n_out_refl;
            r_out_tir   <= r_q11_sd.tir;
            r_out_degen <= n_out_degen;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_reflectance      = r_out_refl;
    assign o_total_reflection = r_out_tir;
    assign o_degenerate       = r_out_degen;

    // Checks on the result flags and on back-pressure.
    `FDR_ASSERT_IMP(a_flags_exclusive, i_clk, i_rst_n, o_valid, !(o_total_reflection && o_degenerate), "total reflection and degenerate both set")
    `FDR_ASSERT_IMP(a_flag_full, i_clk, i_rst_n, o_valid && (o_total_reflection || o_degenerate), o_reflectance == ONE_Q15, "flagged result is not full reflectance")
    `FDR_ASSERT_IMP(a_refl_range, i_clk, i_rst_n, o_valid, o_reflectance <= ONE_Q15, "reflectance above one")
    `FDR_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a held result")

endmodule

### tb/fdr_checker.sv
// Checker for the Fresnel reflectance block: watches the channels, predicts and compares.
`timescale 1ns / 1ps

module fdr_checker
    import fdr_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_stall_in,
    input  logic signed [VECTOR_WIDTH-1:0] i_dir_x,
    input  logic signed [VECTOR_WIDTH-1:0] i_dir_y,
    input  logic signed [VECTOR_WIDTH-1:0] i_dir_z,
    input  logic signed [VECTOR_WIDTH-1:0] i_normal_x,
    input  logic signed [VECTOR_WIDTH-1:0] i_normal_y,
    input  logic signed [VECTOR_WIDTH-1:0] i_normal_z,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [OUT_W-1:0]               i_reflectance,
    input  logic                           i_total_reflection,
    input  logic                           i_degenerate,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [0:0]                     i_cfg_index,
    input  logic [ETA_W-1:0]               i_cfg_data,
    input  logic                           i_drain_done,
    output int                             o_pending,
    output int                             o_errors
);

    // One predicted result.
    typedef struct {
        logic [OUT_W-1:0] refl;
        logic             tir;
        logic             degen;
    } t_fresnel;

    localparam longint unsigned UNIT_Q30 = 64'd1 << 30;

    t_fresnel         expected_refl_q[$];
    logic [ETA_W-1:0] eta_outside;
    logic [ETA_W-1:0] eta_inside;
    int               error_count;
    bit               leftovers_done;

    assign o_pending = expected_refl_q.size();
    assign o_errors  = error_count;

    // Digit-by-digit integer square root.
    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) begin
            b >>= 2;
        end
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scales a vector so that its largest magnitude lies in [2^14, 2^15); 0 if zero.
    function automatic bit normalise(input logic signed [VECTOR_WIDTH-1:0] c0,
                                     input logic signed [VECTOR_WIDTH-1:0] c1,
                                     input logic signed [VECTOR_WIDTH-1:0] c2,
                                     output longint s0, output longint s1,
                                     output longint s2);
        longint          raw [3];
        longint unsigned mag [3];
        longint unsigned top;
        raw[0] = longint'(c0);
        raw[1] = longint'(c1);
        raw[2] = longint'(c2);
        top = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (raw[i] < 0) ? longint'(-raw[i]) : raw[i];
            if (mag[i] > top) begin
                top = mag[i];
            end
        end
        s0 = 0;
        s1 = 0;
        s2 = 0;
        if (top == 0) begin
            return 1'b0;
        end
        while (top >= (64'd1 << 15)) begin
            top >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (top < (64'd1 << 14)) begin
            top <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        s0 = (raw[0] < 0) ? -longint'(mag[0]) : longint'(mag[0]);
        s1 = (raw[1] < 0) ? -longint'(mag[1]) : longint'(mag[1]);
        s2 = (raw[2] < 0) ? -longint'(mag[2]) : longint'(mag[2]);
        return 1'b1;
    endfunction

    // Amplitude ratio |num|/den in Q30 after bringing den below 2^33.
    function automatic longint unsigned amp_ratio(input longint num, input longint unsigned den);
        longint unsigned n;
        n = (num < 0) ? longint'(-num) : num;
        while (den >= (64'd1 << 33)) begin
            den >>= 1;
            n >>= 1;
        end
        if (n > den) begin
            n = den;
        end
        return (n << 30) / den;
    endfunction

    // Expected reflectance of one ray against the current indices.
    function automatic t_fresnel predict_reflectance(
            input logic signed [VECTOR_WIDTH-1:0] dx, input logic signed [VECTOR_WIDTH-1:0] dy,
            input logic signed [VECTOR_WIDTH-1:0] dz, input logic signed [VECTOR_WIDTH-1:0] nx,
            input logic signed [VECTOR_WIDTH-1:0] ny, input logic signed [VECTOR_WIDTH-1:0] nz);
        t_fresnel        r;
        longint          d0, d1, d2, n0, n1, n2, dotv, num_par, num_perp;
        longint unsigned dd, nn, a, len, cosi, sini, sint, cost, eta_in, eta_tr;
        longint unsigned den_par, den_perp, rp, rs, sum, refl;
        bit              ok_d, ok_n;
        r.refl  = ONE_Q15;
        r.tir   = 1'b0;
        r.degen = 1'b1;
        ok_d = normalise(dx, dy, dz, d0, d1, d2);
        ok_n = normalise(nx, ny, nz, n0, n1, n2);
        if (!ok_d || !ok_n) begin
            return r;
        end
        dotv = d0 * n0 + d1 * n1 + d2 * n2;
        dd   = d0 * d0 + d1 * d1 + d2 * d2;
        nn   = n0 * n0 + n1 * n1 + n2 * n2;
        // Back side (or a perpendicular ray): swap the indices.
        if (dotv < 0) begin
            eta_in = eta_outside;
            eta_tr = eta_inside;
            a      = -dotv;
        end else begin
            eta_in = eta_inside;
            eta_tr = eta_outside;
            a      = dotv;
        end
        if (eta_tr == 0) begin
            return r;
        end
        len  = root64(dd * nn);
        cosi = (a << 30) / len;
        if (cosi > UNIT_Q30) cosi = UNIT_Q30;
        sini = root64((UNIT_Q30 << 30) - cosi * cosi);
        // Past the critical angle.
        if (eta_in * sini > eta_tr * UNIT_Q30) begin
            r.tir   = 1'b1;
            r.degen = 1'b0;
            return r;
        end
        sint = (eta_in * sini) / eta_tr;
        if (sint > UNIT_Q30) sint = UNIT_Q30;
        cost = root64((UNIT_Q30 << 30) - sint * sint);
        num_par  = longint'(eta_tr * cosi) - longint'(eta_in * cost);
        den_par  = eta_tr * cosi + eta_in * cost;
        num_perp = longint'(eta_in * cosi) - longint'(eta_tr * cost);
        den_perp = eta_in * cosi + eta_tr * cost;
        if (den_par == 0 || den_perp == 0) begin
            return r;
        end
        rp   = amp_ratio(num_par, den_par);
        rs   = amp_ratio(num_perp, den_perp);
        sum  = rp * rp + rs * rs;
        refl = (sum + (64'd1 << 45)) >> 46;
        if (refl > ONE_Q15) refl = ONE_Q15;
        r.refl  = refl[OUT_W-1:0];
        r.degen = 1'b0;
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what, want, got);
        error_count++;
    endtask

    initial begin
        error_count    = 0;
        leftovers_done = 0;
        eta_outside    = RESET_INDEX_OUTSIDE;
        eta_inside     = RESET_INDEX_INSIDE;
    end

    // Track register writes, predict each request and compare each result.
    always @(posedge i_clk) begin
        t_fresnel want;
        if (!i_rst_n) begin
            eta_outside = RESET_INDEX_OUTSIDE;
            eta_inside  = RESET_INDEX_INSIDE;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_INDEX_OUTSIDE) begin
                    eta_outside = i_cfg_data;
                end else begin
                    eta_inside = i_cfg_data;
                end
            end
            if (i_valid && !i_stall_in) begin
                expected_refl_q.push_back(predict_reflectance(i_dir_x, i_dir_y, i_dir_z,
                                          i_normal_x, i_normal_y, i_normal_z));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_refl_q.size() == 0) begin
                    report_mismatch("unrequested result, reflectance", -1, i_reflectance);
                end else begin
                    want = expected_refl_q.pop_front();
                    if (want.refl !== i_reflectance)
                        report_mismatch("reflectance", want.refl, i_reflectance);
                    if (want.tir !== i_total_reflection)
                        report_mismatch("total_reflection", want.tir, i_total_reflection);
                    if (want.degen !== i_degenerate)
                        report_mismatch("degenerate", want.degen, i_degenerate);
                end
            end
            // Anything still waiting at the end never arrived.
            if (i_drain_done && !leftovers_done) begin
                leftovers_done = 1;
                while (expected_refl_q.size() != 0) begin
                    want = expected_refl_q.pop_front();
                    report_mismatch("missing result, reflectance", want.refl, -1);
                end
            end
        end
    end

endmodule

### tb/tb_top.sv
// Top of the Fresnel reflectance testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import fdr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 260;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic signed [VECTOR_WIDTH-1:0] i_dir_x, i_dir_y, i_dir_z;
    logic signed [VECTOR_WIDTH-1:0] i_normal_x, i_normal_y, i_normal_z;
    logic                           o_valid;
    logic                           i_stall;
    logic [OUT_W-1:0]               o_reflectance;
    logic                           o_total_reflection;
    logic                           o_degenerate;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [0:0]                     i_cfg_index;
    logic [ETA_W-1:0]               i_cfg_data;
    logic                           drain_done;
    int                             pending_results;
    int                             error_total;
    int                             hold_cycles;
    bit                             calm;
    int                             rays_sent;
    int                             phases_run;

    fresnel_dielectric_reflectance u_top (.*);

    fdr_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_normal_x(i_normal_x), .i_normal_y(i_normal_y), .i_normal_z(i_normal_z),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_reflectance(o_reflectance),
        .i_total_reflection(o_total_reflection), .i_degenerate(o_degenerate),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_drain_done(drain_done),
        .o_pending(pending_results), .o_errors(error_total)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Idle length: mostly short, now and then long; none while calm.
    function automatic int idle_len();
        int p;
        p = $urandom_range(99);
        if (calm || p < 55) return 0;
        if (p < 88) return $urandom_range(3, 1);
        if (p < 97) return $urandom_range(15, 4);
        return $urandom_range(60, 20);
    endfunction

    // Receiver back-pressure, with an occasional long hold-off on request.
    initial begin
        int n;
        i_stall <= 1'b0;
        forever begin
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if (calm || $urandom_range(1) == 0) begin
                i_stall <= 1'b0;
                n = calm ? 1 : idle_len() + 1;
                repeat (n) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                n = idle_len() + 1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Global timeout.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** fresnel_dielectric_reflectance: FAILED **");
        $finish;
    end

    // Offers one ray and holds it until accepted, then idles at random.
    task automatic send_ray(input logic signed [15:0] dx, input logic signed [15:0] dy,
                            input logic signed [15:0] dz, input logic signed [15:0] nx,
                            input logic signed [15:0] ny, input logic signed [15:0] nz);
        int gap;
        i_valid    <= 1'b1;
        i_dir_x    <= dx;
        i_dir_y    <= dy;
        i_dir_z    <= dz;
        i_normal_x <= nx;
        i_normal_y <= ny;
        i_normal_z <= nz;
        do @(posedge i_clk); while (o_stall);
        rays_sent++;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lowers valid, then waits for every outstanding result.
    task automatic wait_empty();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    // Writes one index register.
    task automatic write_index(input t_reg_index idx, input logic [ETA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random component of the requested style.
    function automatic logic signed [15:0] rand_comp(input int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(8, 0)) - 4);
            2: return 16'($signed($urandom_range(32767, 0)) - 16384);
            default: return ($urandom_range(3) == 0) ? 16'sh8000 : 16'sh7fff;
        endcase
    endfunction

    // One random ray: mostly well-formed vectors, some noise and edge values.
    task automatic send_random_ray();
        logic signed [15:0] d [3];
        logic signed [15:0] n [3];
        int p, sd, sn, ax;
        p  = $urandom_range(99);
        sd = (p < 60) ? 2 : (p < 75) ? 0 : (p < 90) ? 1 : 3;
        sn = ($urandom_range(3) == 0) ? $urandom_range(3) : 2;
        for (int i = 0; i < 3; i++) begin
            d[i] = rand_comp(sd);
            n[i] = rand_comp(sn);
        end
        // Grazing rays near an axis-aligned normal to reach the critical angle.
        if ($urandom_range(4) == 0) begin
            ax = $urandom_range(2);
            for (int i = 0; i < 3; i++) n[i] = 16'sd0;
            n[ax] = ($urandom_range(1) != 0) ? 16'sd16384 : -16'sd16384;
            d[ax] = 16'($signed($urandom_range(4000, 0)) - 2000);
        end
        if ($urandom_range(60) == 0) begin
            for (int i = 0; i < 3; i++) d[i] = 16'sd0;
        end
        if ($urandom_range(60) == 0) begin
            for (int i = 0; i < 3; i++) n[i] = 16'sd0;
        end
        send_ray(d[0], d[1], d[2], n[0], n[1], n[2]);
    endtask

    // Stimulus.
    initial begin
        logic [ETA_W-1:0] outside_tab [7];
        logic [ETA_W-1:0] inside_tab  [7];
        outside_tab = '{16'd4096, 16'd4096, 16'd65535, 16'd4096, 16'd0, 16'd6144, 16'd4096};
        inside_tab  = '{16'd6144, 16'd65535, 16'd4096, 16'd4096, 16'd6144, 16'd0, 16'd5461};
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_dir_x     <= '0;
        i_dir_y     <= '0;
        i_dir_z     <= '0;
        i_normal_x  <= '0;
        i_normal_y  <= '0;
        i_normal_z  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_INDEX_OUTSIDE;
        i_cfg_data  <= '0;
        drain_done  <= 1'b0;
        hold_cycles = 0;
        calm        = 0;
        rays_sent   = 0;
        phases_run  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rays under the reset indices.
        send_ray(0, 0, 0, 0, 0, 16384);                        // zero direction
        send_ray(0, 0, -16384, 0, 0, 0);                       // zero normal
        send_ray(0, 0, -16384, 0, 0, 16384);                   // normal incidence, front
        send_ray(0, 0, 16384, 0, 0, 16384);                    // normal incidence, back
        send_ray(16384, 0, 0, 0, 0, 16384);                    // perpendicular ray
        send_ray(16384, 0, 900, 0, 0, 16384);                  // grazing from inside: TIR
        send_ray(16384, 0, -900, 0, 0, 16384);                 // grazing from outside
        send_ray(-32768, -32768, -32768, 32767, 32767, 32767); // extremes
        send_ray(32767, 32767, 32767, -32768, -32768, -32768);
        send_ray(1, 0, 0, -1, 0, 0);                           // tiny magnitudes
        send_ray(-1, -1, 1, 0, 1, 0);
        send_ray(11585, 0, -11585, 0, 0, 16384);               // 45 degrees
        send_ray(11585, 0, 11585, 0, 0, 16384);                // 45 degrees from inside
        send_ray(-32768, 0, 0, 32767, 0, 0);
        wait_empty();
        phases_run++;

        // Random phases over several index settings, extremes among them.
        for (int ph = 0; ph < 7; ph++) begin
            write_index(REG_INDEX_OUTSIDE, outside_tab[ph]);
            write_index(REG_INDEX_INSIDE, inside_tab[ph]);
            calm = (ph == 3);
            send_ray(0, 0, -16384, 0, 0, 16384);
            send_ray(16384, 0, 0, 0, 0, 16384);
            send_ray(16384, 0, 1500, 0, 0, -16384);
            // Long receiver hold-off while rays keep coming back to back.
            if (ph == 3) hold_cycles = 600;
            for (int k = 0; k < 215; k++) send_random_ray();
            wait_empty();
            phases_run++;
        end

        // A last phase with random in-range indices.
        write_index(REG_INDEX_OUTSIDE, 16'($urandom_range(65535, 4096)));
        write_index(REG_INDEX_INSIDE, 16'($urandom_range(65535, 4096)));
        calm = 0;
        for (int k = 0; k < 110; k++) send_random_ray();
        wait_empty();
        phases_run++;

        repeat (DRAIN_WAIT) @(posedge i_clk);
        drain_done <= 1'b1;
        repeat (3) @(posedge i_clk);
        $display("Sent %0d rays over %0d index settings, including zero, equal and extreme indices,",
                 rays_sent, phases_run);
        $display("with random gaps, a long output hold-off and a full drain between settings.");
        if (error_total == 0) begin
            $display("** fresnel_dielectric_reflectance: PASSED **");
        end else begin
            $display("** fresnel_dielectric_reflectance: FAILED **");
        end
        $finish;
    end

endmodule
